>>> rtl/emg_env_pkg.sv
// Shared widths, constants and types for the EMG envelope strength block.
// No dependencies; every other file refers to it by scoped names.
package emg_env_pkg;

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int LEVEL_W    = 24;
    localparam int STRENGTH_W = 7;

    // Internal value widths
    localparam int DC_W       = 25;                     // signed DC estimate
    localparam int DIFF_W     = 26;                     // signed differences
    localparam int RECT_W     = 25;                     // rectified sample
    localparam int WIN_LEN    = 32;
    localparam int WIN_AW     = $clog2(WIN_LEN);
    localparam int SUM_W      = RECT_W + WIN_AW;        // window running sum
    localparam int SCALE_W    = 25;                     // smoothed, peak, full scale
    localparam int DIVD_W     = 31;                     // smoothed * 100
    localparam int DIV_CNT_W  = $clog2(DIVD_W);

    // Calibration
    localparam int CAL_SAMPLES = 6000;
    localparam int CAL_W       = 13;

    // Arithmetic constants
    localparam int DC_SHIFT          = 6;               // 1/64 step
    localparam int SMOOTH_SHIFT      = 3;               // 1/8 step
    localparam int PERCENT           = 100;
    localparam int DEFAULT_SCALE     = 1000;
    localparam int DEFAULT_THRESHOLD = 50;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DC     = 7'b0000010,
        S_RECT   = 7'b0000100,
        S_SUM    = 7'b0001000,
        S_SMOOTH = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    // Window memory access bundle
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [WIN_AW-1:0] rd_addr;
        logic              wr_en;
        logic [WIN_AW-1:0] wr_addr;
        logic [RECT_W-1:0] wr_data;
    } win_req_t;

endpackage

>>> rtl/emg_env_win.sv
// Sliding-window sample store: one synchronous memory with a registered read port.
// Per-entry valid bits make cleared entries read as zero. Uses emg_env_pkg.
module emg_env_win (
    input  logic                                clk,
    input  logic                                rst_n,
    input  emg_env_pkg::win_req_t               req,
    output logic [emg_env_pkg::RECT_W-1:0]      rd_data
);

    logic [emg_env_pkg::RECT_W-1:0]  mem [emg_env_pkg::WIN_LEN];
    logic [emg_env_pkg::WIN_LEN-1:0] valid_reg;
    logic [emg_env_pkg::RECT_W-1:0]  rd_data_reg;
    logic                            rd_valid_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Valid bits: cleared at reset and on a clear request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/emg_env_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Used for the strength normalization. Uses emg_env_pkg.
module emg_env_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [emg_env_pkg::DIVD_W-1:0]      dividend,
    input  logic [emg_env_pkg::SCALE_W-1:0]     divisor,
    output logic                                done,
    output logic [emg_env_pkg::DIVD_W-1:0]      quotient
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [emg_env_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [emg_env_pkg::DIVD_W-1:0]       dvd_reg;
    logic [emg_env_pkg::SCALE_W-1:0]      rem_reg;
    logic [emg_env_pkg::SCALE_W-1:0]      dsr_reg;
    logic [emg_env_pkg::SCALE_W:0]        trial;
    logic                                 fits;
    logic [emg_env_pkg::SCALE_W:0]        rem_sub;

    // One trial subtraction; a zero divisor yields all ones
    always_comb
    begin
        trial   = {rem_reg, dvd_reg[emg_env_pkg::DIVD_W-1]};
        fits    = (trial >= {1'b0, dsr_reg});
        rem_sub = trial - {1'b0, dsr_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= emg_env_pkg::DIV_CNT_W'(emg_env_pkg::DIVD_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: quotient bits shift into the dividend register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[emg_env_pkg::DIVD_W-2:0], fits};
            rem_reg <= fits ? rem_sub[emg_env_pkg::SCALE_W-1:0]
                            : trial[emg_env_pkg::SCALE_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> rtl/emg_envelope_strength.sv
// EMG envelope strength detector: DC removal, rectification, sliding window,
// smoothing, normalization and calibration. Uses emg_env_pkg, emg_env_win, emg_env_div.
//
//  channel    dir  signals                          payload
//  s_*        in   s_tvalid s_tready s_tdata s_tuser sample, cal_start
//  m_*        out  m_tvalid m_tready m_tdata m_tuser strength, level, cal flags
//  threshold  in   threshold_we threshold_wdata      noise floor register
//
// An accepted item passes through five sequencer steps and the serial normalization
// divider; the finishing step waits for the divider to finish before the result
// is written to the output register.
// One item is in work at a time; the next is taken once the result is in
// the output register, even if it has not yet been taken downstream.
// A stalled output holds the finishing step until the output register frees.
// Reset is immediate: window valid bits clear at once, no clearing pass.
module emg_envelope_strength (
    input  logic        clk,
    input  logic        rst_n,
    // [23:0] sample
    input  logic [23:0] s_tdata,
    // [0] cal_start
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] strength, [30:7] smoothed_level, [31] zero
    output logic [31:0] m_tdata,
    // [0] calibrating, [1] calibrated
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        threshold_we,
    input  logic [23:0] threshold_wdata
);

    emg_env_pkg::state_t                    state_reg, state_next;
    logic [emg_env_pkg::LEVEL_W-1:0]        threshold_reg;
    logic signed [emg_env_pkg::DC_W-1:0]    dc_reg;
    logic signed [emg_env_pkg::SAMPLE_W-1:0] sample_reg;
    logic [emg_env_pkg::RECT_W-1:0]         rect_reg;
    logic [emg_env_pkg::SUM_W-1:0]          sum_reg;
    logic [emg_env_pkg::WIN_AW-1:0]         ptr_reg;
    logic [emg_env_pkg::SCALE_W-1:0]        smoothed_reg;
    logic [emg_env_pkg::SCALE_W-1:0]        full_scale_reg;
    logic                                   calib_flag_reg;
    logic [emg_env_pkg::CAL_W-1:0]          cal_rem_reg;
    logic [emg_env_pkg::SCALE_W-1:0]        peak_reg;
    logic                                   out_valid_reg;
    logic [emg_env_pkg::STRENGTH_W-1:0]     strength_reg;
    logic [emg_env_pkg::LEVEL_W-1:0]        level_reg;
    logic                                   calibrating_reg;
    logic                                   calibrated_reg;

    logic                                   accept;
    logic                                   fin_go;
    emg_env_pkg::win_req_t                  win_req;
    logic [emg_env_pkg::RECT_W-1:0]         win_old;
    logic signed [emg_env_pkg::DIFF_W-1:0]  dc_diff, dc_step, centered;
    logic signed [emg_env_pkg::DC_W-1:0]    dc_next;
    logic [emg_env_pkg::RECT_W-1:0]         rect_next;
    logic [emg_env_pkg::SUM_W-1:0]          sum_next;
    logic [emg_env_pkg::WIN_AW-1:0]         ptr_next;
    logic [emg_env_pkg::SCALE_W-1:0]        env;
    logic signed [emg_env_pkg::DIFF_W-1:0]  sm_diff, sm_step;
    logic [emg_env_pkg::SCALE_W-1:0]        smoothed_next;
    logic                                   div_start, div_done;
    logic [emg_env_pkg::DIVD_W-1:0]         div_dividend, div_quot;
    logic [emg_env_pkg::STRENGTH_W-1:0]     strength_next;
    logic [emg_env_pkg::CAL_W-1:0]          cal_rem_next;
    logic [emg_env_pkg::SCALE_W-1:0]        peak_next;
    logic                                   below_thr;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == emg_env_pkg::S_IDLE);
    assign fin_go   = (state_reg == emg_env_pkg::S_FIN) && div_done
                      && (!out_valid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            emg_env_pkg::S_IDLE:   if (accept) state_next = emg_env_pkg::S_DC;
            emg_env_pkg::S_DC:     state_next = emg_env_pkg::S_RECT;
            emg_env_pkg::S_RECT:   state_next = emg_env_pkg::S_SUM;
            emg_env_pkg::S_SUM:    state_next = emg_env_pkg::S_SMOOTH;
            emg_env_pkg::S_SMOOTH: state_next = emg_env_pkg::S_DIV;
            emg_env_pkg::S_DIV:    state_next = emg_env_pkg::S_FIN;
            emg_env_pkg::S_FIN:    if (fin_go) state_next = emg_env_pkg::S_IDLE;
            default:               state_next = emg_env_pkg::S_IDLE;
        endcase
    end

    // DC tracking: step of (s - dc) / 64, truncated toward zero
    always_comb
    begin
        dc_diff = emg_env_pkg::DIFF_W'(sample_reg) - emg_env_pkg::DIFF_W'(dc_reg);
        if (dc_diff < 0)
        begin
            dc_step = (dc_diff + emg_env_pkg::DIFF_W'((1 << emg_env_pkg::DC_SHIFT) - 1))
                      >>> emg_env_pkg::DC_SHIFT;
        end
        else
        begin
            dc_step = dc_diff >>> emg_env_pkg::DC_SHIFT;
        end
        dc_next = emg_env_pkg::DC_W'(emg_env_pkg::DIFF_W'(dc_reg) + dc_step);
    end

    // Rectify sample minus the new DC estimate
    always_comb
    begin
        centered  = emg_env_pkg::DIFF_W'(sample_reg) - emg_env_pkg::DIFF_W'(dc_reg);
        rect_next = (centered < 0) ? emg_env_pkg::RECT_W'(-centered)
                                   : emg_env_pkg::RECT_W'(centered);
    end

    // Window sum update and pointer wrap
    always_comb
    begin
        sum_next = sum_reg - emg_env_pkg::SUM_W'(win_old) + emg_env_pkg::SUM_W'(rect_reg);
        if (ptr_reg == emg_env_pkg::WIN_AW'(emg_env_pkg::WIN_LEN - 1))
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    // Smoothing: step of (env - sm) / 8, truncated toward zero
    always_comb
    begin
        env     = emg_env_pkg::SCALE_W'(sum_reg / emg_env_pkg::WIN_LEN);
        sm_diff = emg_env_pkg::DIFF_W'(env) - emg_env_pkg::DIFF_W'(smoothed_reg);
        if (sm_diff < 0)
        begin
            sm_step = (sm_diff + emg_env_pkg::DIFF_W'((1 << emg_env_pkg::SMOOTH_SHIFT) - 1))
                      >>> emg_env_pkg::SMOOTH_SHIFT;
        end
        else
        begin
            sm_step = sm_diff >>> emg_env_pkg::SMOOTH_SHIFT;
        end
        smoothed_next = emg_env_pkg::SCALE_W'(emg_env_pkg::DIFF_W'(smoothed_reg) + sm_step);
    end

    // Window memory access
    always_comb
    begin
        win_req.clear   = accept && s_tuser;
        win_req.rd_en   = (state_reg == emg_env_pkg::S_DC);
        win_req.rd_addr = ptr_reg;
        win_req.wr_en   = (state_reg == emg_env_pkg::S_SUM);
        win_req.wr_addr = ptr_reg;
        win_req.wr_data = rect_reg;
    end

    emg_env_win u_win (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (win_req),
        .rd_data (win_old)
    );

    // Normalization: smoothed * 100 / full_scale
    assign div_start    = (state_reg == emg_env_pkg::S_DIV);
    assign div_dividend = emg_env_pkg::DIVD_W'(smoothed_reg * emg_env_pkg::SCALE_W'(emg_env_pkg::PERCENT));

    emg_env_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (full_scale_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Strength and calibration bookkeeping
    always_comb
    begin
        if (smoothed_reg < emg_env_pkg::SCALE_W'(threshold_reg))
        begin
            strength_next = '0;
        end
        else if (full_scale_reg == '0
                 || div_quot > emg_env_pkg::DIVD_W'(emg_env_pkg::PERCENT))
        begin
            strength_next = emg_env_pkg::STRENGTH_W'(emg_env_pkg::PERCENT);
        end
        else
        begin
            strength_next = div_quot[emg_env_pkg::STRENGTH_W-1:0];
        end
        peak_next    = peak_reg;
        cal_rem_next = cal_rem_reg;
        if (cal_rem_reg != '0)
        begin
            if (smoothed_reg > peak_reg)
            begin
                peak_next = smoothed_reg;
            end
            cal_rem_next = cal_rem_reg - 1'b1;
        end
        below_thr = (peak_next < emg_env_pkg::SCALE_W'(threshold_reg));
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= emg_env_pkg::S_IDLE;
            threshold_reg  <= emg_env_pkg::LEVEL_W'(emg_env_pkg::DEFAULT_THRESHOLD);
            dc_reg         <= '0;
            sum_reg        <= '0;
            ptr_reg        <= '0;
            smoothed_reg   <= '0;
            full_scale_reg <= emg_env_pkg::SCALE_W'(emg_env_pkg::DEFAULT_SCALE);
            calib_flag_reg <= 1'b0;
            cal_rem_reg    <= '0;
            peak_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (threshold_we)
            begin
                threshold_reg <= threshold_wdata;
            end
            // Calibration start clears the envelope
            if (accept && s_tuser)
            begin
                sum_reg      <= '0;
                ptr_reg      <= '0;
                smoothed_reg <= '0;
                peak_reg     <= '0;
                cal_rem_reg  <= emg_env_pkg::CAL_W'(emg_env_pkg::CAL_SAMPLES);
            end
            if (state_reg == emg_env_pkg::S_DC)
            begin
                dc_reg <= dc_next;
            end
            if (state_reg == emg_env_pkg::S_SUM)
            begin
                sum_reg <= sum_next;
                ptr_reg <= ptr_next;
            end
            if (state_reg == emg_env_pkg::S_SMOOTH)
            begin
                smoothed_reg <= smoothed_next;
            end
            if (fin_go)
            begin
                peak_reg    <= peak_next;
                cal_rem_reg <= cal_rem_next;
                if (cal_rem_reg != '0 && cal_rem_next == '0)
                begin
                    full_scale_reg <= below_thr
                        ? emg_env_pkg::SCALE_W'(emg_env_pkg::DEFAULT_SCALE) : peak_next;
                    calib_flag_reg <= !below_thr;
                end
            end
            // Output register
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata;
        end
        if (state_reg == emg_env_pkg::S_RECT)
        begin
            rect_reg <= rect_next;
        end
        if (fin_go)
        begin
            strength_reg    <= strength_next;
            level_reg       <= smoothed_reg[emg_env_pkg::LEVEL_W-1:0];
            calibrating_reg <= (cal_rem_next != '0);
            calibrated_reg  <= (cal_rem_reg != '0 && cal_rem_next == '0)
                               ? !below_thr : calib_flag_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, level_reg, strength_reg};
    assign m_tuser  = {calibrated_reg, calibrating_reg};

    // Checks
    a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= 7'd100))
        else $error("strength above 100");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= emg_env_pkg::WIN_AW'(emg_env_pkg::WIN_LEN - 1))
        else $error("window pointer out of range");

    a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |-> $past(state_reg) != emg_env_pkg::S_DIV)
        else $error("result taken before divider finished");

endmodule

>>> tb/sv/tb_emg_envelope_strength.sv
// Self-checking testbench for emg_envelope_strength: directed, calibration, back-pressure
// and random streams, checked against an in-bench envelope predictor.
// Depends on emg_env_pkg and the emg_envelope_strength RTL only.
module tb_emg_envelope_strength;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WINDOW        = emg_env_pkg::WIN_LEN;
    localparam int     CAL_RUN       = emg_env_pkg::CAL_SAMPLES;
    localparam longint DC_DIV        = 64;
    localparam longint SMOOTH_DIV    = 8;
    localparam longint PERCENT       = 100;
    localparam longint DEFAULT_SCALE = 1000;
    localparam longint DEFAULT_FLOOR = 50;
    localparam logic [23:0] FLOOR_MAX = 24'hFFFFFF;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     MAX_PRINTS    = 40;

    // Expected output reading for one sample
    typedef struct packed {
        logic [6:0]  strength;
        logic [23:0] level;
        logic        calibrating;
        logic        calibrated;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        threshold_we = 1'b0;
    logic [23:0] threshold_wdata = '0;

    emg_envelope_strength uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .threshold_we    (threshold_we),
        .threshold_wdata (threshold_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state, at reset values
    longint   floor_level = DEFAULT_FLOOR;
    longint   dc_est      = 0;
    longint   win_rect[WINDOW];
    longint   win_sum     = 0;
    int       win_ptr     = 0;
    longint   smooth_lvl  = 0;
    longint   full_scale  = DEFAULT_SCALE;
    bit       cal_done    = 1'b0;
    int       cal_left    = 0;
    longint   cal_peak    = 0;

    reading_t expected_readings[$];
    int       mismatches       = 0;
    int       readings_checked = 0;

    // Pacing controls
    bit       pace_gaps   = 1'b1;
    bit       pace_stalls = 1'b1;
    int       burst_left  = 0;
    int       hold_req    = 0;

    initial
    begin
        foreach (win_rect[i])
            win_rect[i] = 0;
    end

    // Envelope predictor: DC removal, rectify, window average, smoothing,
    // normalization and calibration tracking for one accepted sample
    function automatic reading_t envelope_step(input logic [23:0] smp, input logic cal);
        longint   s;
        longint   centered;
        longint   rect;
        longint   env;
        longint   pct;
        reading_t r;
        s = longint'($signed(smp));
        if (cal)
        begin
            foreach (win_rect[i])
                win_rect[i] = 0;
            win_sum    = 0;
            win_ptr    = 0;
            smooth_lvl = 0;
            cal_peak   = 0;
            cal_left   = CAL_RUN;
        end

        dc_est   = dc_est + (s - dc_est) / DC_DIV;
        centered = s - dc_est;
        rect     = (centered < 0) ? -centered : centered;

        win_sum           = win_sum - win_rect[win_ptr] + rect;
        win_rect[win_ptr] = rect;
        win_ptr           = (win_ptr + 1) % WINDOW;

        env        = win_sum / WINDOW;
        smooth_lvl = smooth_lvl + (env - smooth_lvl) / SMOOTH_DIV;

        // Strength uses the scale in force before this sample's calibration update
        if (smooth_lvl < floor_level)
            pct = 0;
        else if (full_scale == 0)
            pct = PERCENT;
        else
        begin
            pct = (smooth_lvl * PERCENT) / full_scale;
            if (pct > PERCENT)
                pct = PERCENT;
        end

        if (cal_left != 0)
        begin
            if (smooth_lvl > cal_peak)
                cal_peak = smooth_lvl;
            cal_left--;
            if (cal_left == 0)
            begin
                if (cal_peak < floor_level)
                begin
                    full_scale = DEFAULT_SCALE;
                    cal_done   = 1'b0;
                end
                else
                begin
                    full_scale = cal_peak;
                    cal_done   = 1'b1;
                end
            end
        end

        r.strength    = pct[6:0];
        r.level       = smooth_lvl[23:0];
        r.calibrating = (cal_left != 0);
        r.calibrated  = cal_done;
        return r;
    endfunction

    // Random sample around an offset, clamped to the converter range
    function automatic logic [23:0] rand_sample(input int amp, input int ofs);
        int v;
        v = ofs + int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTS)
            $display("MISMATCH %s at reading %0d: got %0d, want %0d",
                     what, readings_checked, got, want);
        mismatches++;
    endtask

    // Sender: bursts of transactions separated by random gaps
    task automatic send_item(input logic [23:0] smp, input logic cal);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (pace_gaps)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 45) : $urandom_range(0, 4);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= smp;
        s_tuser  <= cal;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        expected_readings.push_back(envelope_step(smp, cal));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [23:0] v);
        threshold_wdata <= v;
        threshold_we    <= 1'b1;
        @(posedge clk);
        threshold_we    <= 1'b0;
        floor_level = longint'(v);
    endtask

    // Receiver: its own ready/stall pattern, plus long hold-offs on request
    int  hold_seen  = 0;
    int  hold_left  = 0;
    int  run_left   = 0;
    bit  run_ready  = 1'b0;

    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!pace_stalls)
            m_tready <= 1'b1;
        else
        begin
            if (run_left == 0)
            begin
                run_ready = !run_ready;
                if (run_ready)
                    run_left = $urandom_range(1, 30);
                else
                    run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                                           : $urandom_range(1, 5);
            end
            run_left--;
            m_tready <= run_ready;
        end
    end

    // Result checker: each output transaction against the oldest expectation
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("unexpected result, strength", m_tdata[6:0], 0);
            else
            begin
                want = expected_readings.pop_front();
                if (m_tdata[6:0] != want.strength)
                    report_mismatch("strength", m_tdata[6:0], want.strength);
                if (m_tdata[30:7] != want.level)
                    report_mismatch("smoothed_level", m_tdata[30:7], want.level);
                if (m_tdata[31] != 1'b0)
                    report_mismatch("tdata pad bit", m_tdata[31], 0);
                if (m_tuser[0] != want.calibrating)
                    report_mismatch("calibrating", m_tuser[0], want.calibrating);
                if (m_tuser[1] != want.calibrated)
                    report_mismatch("calibrated", m_tuser[1], want.calibrated);
            end
            readings_checked++;
        end
    end

    // Sample extremes, sign boundaries, calibration start and restart mid-run
    task automatic test_directed_extremes();
        send_item(24'h000000, 1'b0);
        send_item(24'h7FFFFF, 1'b0);
        send_item(24'h800000, 1'b0);
        send_item(24'h7FFFFF, 1'b0);
        send_item(24'h800000, 1'b0);
        send_item(24'hFFFFFF, 1'b0);
        send_item(24'h000001, 1'b0);
        send_item(24'h7FFFFF, 1'b1);
        send_item(24'h800000, 1'b0);
        send_item(24'h000000, 1'b0);
        send_item(24'h7FFFFF, 1'b1);
        send_item(24'h800000, 1'b0);
        send_item(24'h555555, 1'b0);
        send_item(24'hAAAAAA, 1'b0);
        wait_idle();
    endtask

    // Noise floor at both ends of its range
    task automatic test_threshold_extremes();
        set_threshold(24'd0);
        send_item(24'h7FFFFF, 1'b0);
        send_item(24'h800000, 1'b0);
        send_item(24'h000000, 1'b0);
        wait_idle();
        set_threshold(FLOOR_MAX);
        send_item(24'h7FFFFF, 1'b0);
        send_item(24'h800000, 1'b0);
        send_item(24'h000000, 1'b0);
        wait_idle();
    endtask

    // Calibration with strong activity, restarted partway: peak tracking
    // and the calibrating flag while the run is in progress
    task automatic test_calibration_to_peak();
        int amp;
        int ofs;
        set_threshold(24'($urandom_range(1, 5000)));
        amp = 1000;
        ofs = 0;
        for (int i = 0; i < 160; i++)
        begin
            if (i % 40 == 0)
            begin
                amp = $urandom_range(1000, 3000000);
                ofs = int'($urandom_range(0, 2000000)) - 1000000;
            end
            send_item(rand_sample(amp, ofs), i == 0 || i == 80);
        end
        wait_idle();
    endtask

    // Calibration start under the highest floor: strength stays zero
    task automatic test_calibration_below_floor();
        set_threshold(FLOOR_MAX);
        for (int i = 0; i < 100; i++)
            send_item(rand_sample(2000000, 0), i == 0);
        wait_idle();
    endtask

    // Flat input with zero floor during a run (level stays at zero), then random samples
    task automatic test_calibration_zero_scale();
        set_threshold(24'd0);
        for (int i = 0; i < 100; i++)
            send_item(dc_est[23:0], i == 0);
        for (int i = 0; i < 30; i++)
            send_item(rand_sample($urandom_range(0, 500000), 0), 1'b0);
        wait_idle();
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_output_backpressure();
        set_threshold(24'd50);
        pace_gaps = 1'b0;
        hold_req++;
        for (int i = 0; i < 30; i++)
            send_item(rand_sample(400000, 1000), 1'b0);
        pace_gaps = 1'b1;
        wait_idle();
    endtask

    // Random activity in phases with different noise floors
    task automatic test_random_activity();
        logic [23:0] floors[4];
        int          amp;
        int          ofs;
        logic [23:0] smp;
        logic        cal;
        floors[0] = 24'($urandom_range(0, 3000));
        floors[1] = 24'd0;
        floors[2] = 24'($urandom_range(0, 24'hFFFFFF));
        floors[3] = 24'($urandom_range(20, 200));
        amp = 0;
        ofs = 0;
        for (int p = 0; p < 4; p++)
        begin
            set_threshold(floors[p]);
            for (int i = 0; i < 300; i++)
            begin
                // New signal shape; some stretches without idling
                if (i % 50 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: amp = $urandom_range(0, 200);
                        1: amp = $urandom_range(200, 100000);
                        default: amp = $urandom_range(100000, 4000000);
                    endcase
                    ofs = int'($urandom_range(0, 4000000)) - 2000000;
                    pace_gaps   = ($urandom_range(0, 3) != 0);
                    pace_stalls = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 9) == 0)
                    smp = 24'($urandom());
                else
                    smp = rand_sample(amp, ofs);
                cal = ($urandom_range(0, 249) == 0);
                send_item(smp, cal);
            end
            wait_idle();
        end
        pace_gaps   = 1'b1;
        pace_stalls = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_threshold_extremes();
        test_calibration_to_peak();
        test_calibration_below_floor();
        test_calibration_zero_scale();
        test_output_backpressure();
        test_random_activity();
        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit
    initial
    begin
        #250ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
